[rtl/core/accelerated_encoder_value_entry_macros.svh]
`ifndef ACCELERATED_ENCODER_VALUE_ENTRY_MACROS_SVH
`define ACCELERATED_ENCODER_VALUE_ENTRY_MACROS_SVH

// check a condition at every clock edge outside reset
`define AEVE_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// check that a condition holds in the cycle after a trigger
`define AEVE_ASSERT_NEXT(label, trig, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error("assertion failed");

`endif

[rtl/core/aeve_pkg.sv]
`default_nettype none

package aeve_pkg;

  localparam int VAL_W   = 16;
  localparam int STEP_W  = 16;
  localparam int TIME_W  = 32;
  localparam int FC_W    = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int FAST_COUNT_LIMIT_DEF = 100;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] CAUSE_RUN     = 2'd0;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
  localparam logic [1:0] CAUSE_BUTTON  = 2'd2;

  localparam logic [1:0] CODE_BOTH = 2'd3;
  localparam logic [1:0] CODE_UP   = 2'd2;
  localparam logic [1:0] CODE_DOWN = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_WINDOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_CAP    = 3'd5;

  typedef struct packed {
    logic              op;
    logic [VAL_W-1:0]  start_value;
    logic [1:0]        code;
    logic              button_level;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

endpackage

`default_nettype wire

[rtl/core/accelerated_encoder_value_entry.sv]
`default_nettype none

// Knob value entry with acceleration. A word enters an input register, and from
// there the update of value, step, fast counter and session state is
// done in one pass of add/compare logic and a 16x8 multiplier, landing in the
// result register. One word is taken every clock when the result side does
// not stall. Registers are written by index on the cfg_ port; the user must
// write them only while no word is in flight, as the block does not enforce it;
// cfg_ready is always high.
`include "accelerated_encoder_value_entry_macros.svh"

module accelerated_encoder_value_entry
  import aeve_pkg::*;
#(
  parameter int FAST_COUNT_LIMIT = FAST_COUNT_LIMIT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_op,
  input  wire logic [VAL_W-1:0]      in_start_value,
  input  wire logic                  in_line_a,
  input  wire logic                  in_line_b,
  input  wire logic                  in_button_level,
  input  wire logic [TIME_W-1:0]     in_now_ms,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [VAL_W-1:0]           out_value,
  output logic [STEP_W-1:0]          out_step_size,
  output logic                       out_done_res,
  output logic [1:0]                 out_done_cause,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [FC_W-1:0] FC_LIMIT = FC_W'(FAST_COUNT_LIMIT);

  logic [VAL_W-1:0]  max_value_r, min_value_r, timeout_r, step_cap_r;
  logic [7:0]        accel_r, window_r;

  logic              s1_valid_r;
  in_word_t          s1_r;
  logic              advance;

  logic [VAL_W-1:0]  value_r, value_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        prev_code_r, prev_code_nxt;
  logic [FC_W-1:0]   fast_count_r, fast_count_nxt;
  logic [TIME_W-1:0] last_edge_r, last_edge_nxt;
  logic              finished_r, finished_nxt;
  logic [1:0]        reason_r, reason_nxt;

  logic              out_valid_r;
  logic [VAL_W-1:0]  out_value_r;
  logic [STEP_W-1:0] out_step_r;
  logic              out_done_r;
  logic [1:0]        out_cause_r;

  logic              up_edge, down_edge;
  logic [VAL_W:0]    up_sum, down_diff;
  logic [TIME_W-1:0] elapsed;
  logic [FC_W-1:0]   fc_inc;
  logic [23:0]       grown;
  logic [STEP_W-1:0] cap_eff;
  logic [STEP_W-1:0] grown_capped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_value_r <= 16'd9999;
      min_value_r <= 16'd0;
      accel_r     <= 8'd10;
      window_r    <= 8'd180;
      timeout_r   <= 16'd5000;
      step_cap_r  <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_VALUE:   max_value_r <= cfg_data;
        REG_MIN_VALUE:   min_value_r <= cfg_data;
        REG_ACCEL:       accel_r     <= cfg_data[7:0];
        REG_FAST_WINDOW: window_r    <= cfg_data[7:0];
        REG_TIMEOUT:     timeout_r   <= cfg_data;
        REG_STEP_CAP:    step_cap_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r.op           <= in_op;
      s1_r.start_value  <= in_start_value;
      s1_r.code         <= {in_line_b, in_line_a};
      s1_r.button_level <= in_button_level;
      s1_r.now_ms       <= in_now_ms;
    end
  end

  assign up_edge   = (prev_code_r == CODE_BOTH) && (s1_r.code == CODE_UP);
  assign down_edge = (prev_code_r == CODE_BOTH) && (s1_r.code == CODE_DOWN);
  assign up_sum    = {1'b0, value_r} + {1'b0, step_r};
  assign down_diff = {1'b0, value_r} - {1'b0, step_r};
  assign grown     = {8'd0, step_r} * {16'd0, accel_r};
  assign cap_eff   = (step_cap_r == '0) ? STEP_W'(1) : step_cap_r;

  always_comb begin
    if (grown > {8'd0, cap_eff}) begin
      grown_capped = cap_eff;
    end else begin
      grown_capped = grown[STEP_W-1:0];
    end
    if (grown_capped == '0) begin
      grown_capped = STEP_W'(1);
    end
  end

  always_comb begin
    value_nxt      = value_r;
    step_nxt       = step_r;
    prev_code_nxt  = prev_code_r;
    fast_count_nxt = fast_count_r;
    last_edge_nxt  = last_edge_r;
    finished_nxt   = finished_r;
    reason_nxt     = reason_r;
    elapsed        = '0;
    fc_inc         = fast_count_r + FC_W'(1);
    if (s1_r.op == OP_START) begin
      value_nxt      = s1_r.start_value;
      last_edge_nxt  = s1_r.now_ms;
      step_nxt       = STEP_W'(1);
      fast_count_nxt = '0;
      prev_code_nxt  = '0;
      finished_nxt   = 1'b0;
      reason_nxt     = CAUSE_RUN;
    end else if (!finished_r) begin
      prev_code_nxt = s1_r.code;
      if (up_edge) begin
        last_edge_nxt = s1_r.now_ms;
        value_nxt = (up_sum > {1'b0, max_value_r}) ? max_value_r : up_sum[VAL_W-1:0];
      end else if (down_edge) begin
        last_edge_nxt = s1_r.now_ms;
        if (down_diff[VAL_W] || (down_diff[VAL_W-1:0] < min_value_r)) begin
          value_nxt = min_value_r;
        end else begin
          value_nxt = down_diff[VAL_W-1:0];
        end
      end
      elapsed = s1_r.now_ms - last_edge_nxt;
      if (elapsed < {24'd0, window_r}) begin
        fast_count_nxt = fc_inc;
        if (fc_inc > FC_LIMIT) begin
          step_nxt       = grown_capped;
          fast_count_nxt = '0;
        end
      end else begin
        step_nxt = STEP_W'(1);
      end
      if (elapsed > {16'd0, timeout_r}) begin
        finished_nxt = 1'b1;
        reason_nxt   = CAUSE_TIMEOUT;
      end else if (!s1_r.button_level) begin
        finished_nxt = 1'b1;
        reason_nxt   = CAUSE_BUTTON;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r      <= '0;
      step_r       <= STEP_W'(1);
      prev_code_r  <= '0;
      fast_count_r <= '0;
      last_edge_r  <= '0;
      finished_r   <= 1'b1;
      reason_r     <= CAUSE_RUN;
      out_valid_r  <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        value_r      <= value_nxt;
        step_r       <= step_nxt;
        prev_code_r  <= prev_code_nxt;
        fast_count_r <= fast_count_nxt;
        last_edge_r  <= last_edge_nxt;
        finished_r   <= finished_nxt;
        reason_r     <= reason_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_value_r <= value_nxt;
      out_step_r  <= step_nxt;
      out_done_r  <= finished_nxt;
      out_cause_r <= reason_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_step_size  = out_step_r;
  assign out_done_res   = out_done_r;
  assign out_done_cause = out_cause_r;

  `AEVE_ASSERT_ALWAYS(a_reason_implies_done, (reason_r == CAUSE_RUN) || finished_r)
  `AEVE_ASSERT_ALWAYS(a_step_nonzero, step_r != '0)
  `AEVE_ASSERT_ALWAYS(a_fast_count_bound, fast_count_r <= FC_LIMIT)
  `AEVE_ASSERT_NEXT(a_word_reaches_out, s1_valid_r && advance, out_valid_r)

endmodule

`default_nettype wire
